FILE: hw/rtl/alu_with_condition_flags_defines.svh
// assertion macros for the condition-flag alu
`ifndef ALU_WITH_CONDITION_FLAGS_DEFINES_SVH
`define ALU_WITH_CONDITION_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define ACF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("acf check failed");
// checked on every edge, reset included
`define ACF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("acf check failed at any time");
`else
`define ACF_ASSERT(label, prop)
`define ACF_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: hw/rtl/acf_pkg.sv
package acf_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLCA  = 5'd10,
        OP_RRCA  = 5'd11,
        OP_RLA   = 5'd12,
        OP_RRA   = 5'd13,
        OP_DAA   = 5'd14,
        OP_CPL   = 5'd15,
        OP_SCF   = 5'd16,
        OP_CCF   = 5'd17,
        OP_RLC   = 5'd18,
        OP_RRC   = 5'd19,
        OP_RL    = 5'd20,
        OP_RR    = 5'd21,
        OP_SLA   = 5'd22,
        OP_SRA   = 5'd23,
        OP_SWAP  = 5'd24,
        OP_SRL   = 5'd25,
        OP_BIT   = 5'd26,
        OP_RES   = 5'd27,
        OP_SET   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADDSP = 5'd30
    } acf_op_t;

    // decimal adjust constants
    localparam logic [7:0] DAA_LOW_ADJ    = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ   = 8'h60;
    localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LOW_LIMIT  = 4'h9;

    typedef struct packed {
        logic [4:0]  operation;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic        zero_in;
        logic        subtract_in;
        logic        half_carry_in;
        logic        carry_in;
    } acf_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic        zero_out;
        logic        subtract_out;
        logic        half_carry_out;
        logic        carry_out;
    } acf_rsp_t;

    // per-flag control: calc picks the computed value, else the fixed val
    typedef struct packed {
        logic z_calc;
        logic z_val;
        logic n_val;
        logic h_calc;
        logic h_val;
        logic c_calc;
        logic c_val;
        logic inv;   // subtraction: carries read as borrows
        logic w16;   // take h from bit 11 and c from bit 15
    } acf_flag_ctl_t;

    typedef struct packed {
        logic [15:0]   x;
        logic [15:0]   y;
        logic          cin;
        logic          wide;
        logic          use_sum;
        logic [7:0]    alt;
        logic          clear;
        logic          wb;
        acf_flag_ctl_t fl;
    } acf_dec_t;

    typedef struct packed {
        logic [15:0]   val;
        logic          hc;
        logic          cc;
        logic          clear;
        logic          wb;
        acf_flag_ctl_t fl;
    } acf_sum_t;

endpackage

FILE: hw/rtl/acf_decode.sv
module acf_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  acf_pkg::acf_req_t request,
    output logic              dec_valid,
    output acf_pkg::acf_dec_t dec
);

    logic              valid_reg;
    acf_pkg::acf_dec_t dec_reg;
    acf_pkg::acf_dec_t dec_next;

    always_comb
    begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] mask;
        logic [7:0] corr;
        logic       c;
        logic       shift_op;
        a        = request.operand_a[7:0];
        b        = request.operand_b[7:0];
        c        = request.carry_in;
        mask     = 8'b1 << request.bit_index;
        corr     = 8'h00;
        shift_op = 1'b0;

        dec_next           = '0;
        dec_next.x         = {8'h00, a};
        dec_next.wb        = 1'b1;
        dec_next.fl.z_val  = request.zero_in;
        dec_next.fl.n_val  = request.subtract_in;
        dec_next.fl.h_val  = request.half_carry_in;
        dec_next.fl.c_val  = c;

        unique case (acf_pkg::acf_op_t'(request.operation)) inside
            acf_pkg::OP_ADD, acf_pkg::OP_ADC:
            begin
                dec_next.y         = {8'h00, b};
                dec_next.cin       = (request.operation == acf_pkg::OP_ADC) ? c : 1'b0;
                dec_next.use_sum   = 1'b1;
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.n_val  = 1'b0;
                dec_next.fl.h_calc = 1'b1;
                dec_next.fl.c_calc = 1'b1;
            end
            acf_pkg::OP_SUB, acf_pkg::OP_SBC, acf_pkg::OP_CP:
            begin
                // a - b - ci as a + ~b + !ci
                dec_next.y         = {8'h00, ~b};
                dec_next.cin       = ~((request.operation == acf_pkg::OP_SBC) ? c : 1'b0);
                dec_next.use_sum   = 1'b1;
                dec_next.fl.inv    = 1'b1;
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.n_val  = 1'b1;
                dec_next.fl.h_calc = 1'b1;
                dec_next.fl.c_calc = 1'b1;
                if (request.operation == acf_pkg::OP_CP)
                begin
                    dec_next.clear = 1'b1;
                    dec_next.wb    = 1'b0;
                end
            end
            acf_pkg::OP_AND:
            begin
                dec_next.alt       = a & b;
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.n_val  = 1'b0;
                dec_next.fl.h_val  = 1'b1;
                dec_next.fl.c_val  = 1'b0;
            end
            acf_pkg::OP_XOR, acf_pkg::OP_OR:
            begin
                dec_next.alt       = (request.operation == acf_pkg::OP_XOR) ? (a ^ b) : (a | b);
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.n_val  = 1'b0;
                dec_next.fl.h_val  = 1'b0;
                dec_next.fl.c_val  = 1'b0;
            end
            acf_pkg::OP_INC:
            begin
                dec_next.y         = 16'h0001;
                dec_next.use_sum   = 1'b1;
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.n_val  = 1'b0;
                dec_next.fl.h_calc = 1'b1;
            end
            acf_pkg::OP_DEC:
            begin
                dec_next.y         = 16'h00FF;
                dec_next.use_sum   = 1'b1;
                dec_next.fl.inv    = 1'b1;
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.n_val  = 1'b1;
                dec_next.fl.h_calc = 1'b1;
            end
            acf_pkg::OP_RLCA:
            begin
                dec_next.alt = {a[6:0], a[7]};
                dec_next.fl.c_val = a[7];
            end
            acf_pkg::OP_RRCA:
            begin
                dec_next.alt = {a[0], a[7:1]};
                dec_next.fl.c_val = a[0];
            end
            acf_pkg::OP_RLA:
            begin
                dec_next.alt = {a[6:0], c};
                dec_next.fl.c_val = a[7];
            end
            acf_pkg::OP_RRA:
            begin
                dec_next.alt = {c, a[7:1]};
                dec_next.fl.c_val = a[0];
            end
            acf_pkg::OP_DAA:
            begin
                if (request.subtract_in)
                begin
                    if (c)
                        corr = corr | acf_pkg::DAA_HIGH_ADJ;
                    if (request.half_carry_in)
                        corr = corr | acf_pkg::DAA_LOW_ADJ;
                    dec_next.y   = {8'h00, ~corr};
                    dec_next.cin = 1'b1;
                end
                else
                begin
                    if (c || (a > acf_pkg::DAA_HIGH_LIMIT))
                    begin
                        corr = corr | acf_pkg::DAA_HIGH_ADJ;
                        dec_next.fl.c_val = 1'b1;
                    end
                    if (request.half_carry_in || (a[3:0] > acf_pkg::DAA_LOW_LIMIT))
                        corr = corr | acf_pkg::DAA_LOW_ADJ;
                    dec_next.y = {8'h00, corr};
                end
                dec_next.use_sum   = 1'b1;
                dec_next.fl.z_calc = 1'b1;
                dec_next.fl.h_val  = 1'b0;
            end
            acf_pkg::OP_CPL:
            begin
                dec_next.alt      = ~a;
                dec_next.fl.n_val = 1'b1;
                dec_next.fl.h_val = 1'b1;
            end
            acf_pkg::OP_SCF, acf_pkg::OP_CCF:
            begin
                dec_next.wb       = 1'b0;
                dec_next.fl.n_val = 1'b0;
                dec_next.fl.h_val = 1'b0;
                dec_next.fl.c_val = (request.operation == acf_pkg::OP_SCF) ? 1'b1 : ~c;
            end
            acf_pkg::OP_RLC:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {a[6:0], a[7]};
                dec_next.fl.c_val = a[7];
            end
            acf_pkg::OP_RRC:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {a[0], a[7:1]};
                dec_next.fl.c_val = a[0];
            end
            acf_pkg::OP_RL:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {a[6:0], c};
                dec_next.fl.c_val = a[7];
            end
            acf_pkg::OP_RR:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {c, a[7:1]};
                dec_next.fl.c_val = a[0];
            end
            acf_pkg::OP_SLA:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {a[6:0], 1'b0};
                dec_next.fl.c_val = a[7];
            end
            acf_pkg::OP_SRA:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {a[7], a[7:1]};
                dec_next.fl.c_val = a[0];
            end
            acf_pkg::OP_SWAP:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {a[3:0], a[7:4]};
                dec_next.fl.c_val = 1'b0;
            end
            acf_pkg::OP_SRL:
            begin
                shift_op          = 1'b1;
                dec_next.alt      = {1'b0, a[7:1]};
                dec_next.fl.c_val = a[0];
            end
            acf_pkg::OP_BIT:
            begin
                dec_next.wb       = 1'b0;
                dec_next.fl.z_val = ~|(a & mask);
                dec_next.fl.n_val = 1'b0;
                dec_next.fl.h_val = 1'b1;
            end
            acf_pkg::OP_RES:
            begin
                dec_next.alt = a & ~mask;
            end
            acf_pkg::OP_SET:
            begin
                dec_next.alt = a | mask;
            end
            acf_pkg::OP_ADD16:
            begin
                dec_next.x         = request.operand_a;
                dec_next.y         = request.operand_b;
                dec_next.wide      = 1'b1;
                dec_next.use_sum   = 1'b1;
                dec_next.fl.w16    = 1'b1;
                dec_next.fl.n_val  = 1'b0;
                dec_next.fl.h_calc = 1'b1;
                dec_next.fl.c_calc = 1'b1;
            end
            acf_pkg::OP_ADDSP:
            begin
                dec_next.x         = request.operand_a;
                dec_next.y         = {{8{b[7]}}, b};
                dec_next.wide      = 1'b1;
                dec_next.use_sum   = 1'b1;
                dec_next.fl.z_val  = 1'b0;
                dec_next.fl.n_val  = 1'b0;
                dec_next.fl.h_calc = 1'b1;
                dec_next.fl.c_calc = 1'b1;
            end
            default:
            begin
                dec_next.wb = 1'b0;
            end
        endcase

        // accumulator rotates clear z, n, h
        if ((request.operation == acf_pkg::OP_RLCA) || (request.operation == acf_pkg::OP_RRCA) ||
            (request.operation == acf_pkg::OP_RLA) || (request.operation == acf_pkg::OP_RRA))
        begin
            dec_next.fl.z_val = 1'b0;
            dec_next.fl.n_val = 1'b0;
            dec_next.fl.h_val = 1'b0;
        end

        // cb rotates and shifts set z from the result
        if (shift_op)
        begin
            dec_next.fl.z_calc = 1'b1;
            dec_next.fl.n_val  = 1'b0;
            dec_next.fl.h_val  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

FILE: hw/rtl/acf_adder.sv
module acf_adder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              dec_valid,
    input  acf_pkg::acf_dec_t dec,
    output logic              sum_valid,
    output acf_pkg::acf_sum_t sum
);

    logic              valid_reg;
    acf_pkg::acf_sum_t sum_reg;
    acf_pkg::acf_sum_t sum_next;
    logic [16:0]       full;
    logic              c4;
    logic              c8;
    logic              c12;

    assign full = {1'b0, dec.x} + {1'b0, dec.y} + {16'h0000, dec.cin};

    // carry into a bit position recovered from the sum bit
    assign c4  = dec.x[4] ^ dec.y[4] ^ full[4];
    assign c8  = dec.x[8] ^ dec.y[8] ^ full[8];
    assign c12 = dec.x[12] ^ dec.y[12] ^ full[12];

    always_comb
    begin
        sum_next.clear = dec.clear;
        sum_next.wb    = dec.wb;
        sum_next.fl    = dec.fl;
        sum_next.hc    = dec.fl.w16 ? c12 : c4;
        sum_next.cc    = dec.fl.w16 ? full[16] : c8;
        if (!dec.use_sum)
            sum_next.val = {8'h00, dec.alt};
        else if (dec.wide)
            sum_next.val = full[15:0];
        else
            sum_next.val = {8'h00, full[7:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum_valid = valid_reg;
    assign sum       = sum_reg;

endmodule

FILE: hw/rtl/acf_flags.sv
module acf_flags (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sum_valid,
    input  acf_pkg::acf_sum_t sum,
    output logic              done,
    output acf_pkg::acf_rsp_t response
);

    logic              done_reg;
    acf_pkg::acf_rsp_t rsp_reg;
    acf_pkg::acf_rsp_t rsp_next;

    always_comb
    begin
        rsp_next.result         = sum.clear ? 16'h0000 : sum.val;
        rsp_next.write_back     = sum.wb;
        rsp_next.zero_out       = sum.fl.z_calc ? (sum.val == 16'h0000) : sum.fl.z_val;
        rsp_next.subtract_out   = sum.fl.n_val;
        rsp_next.half_carry_out = sum.fl.h_calc ? (sum.hc ^ sum.fl.inv) : sum.fl.h_val;
        rsp_next.carry_out      = sum.fl.c_calc ? (sum.cc ^ sum.fl.inv) : sum.fl.c_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sum_valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done     = done_reg;
    assign response = rsp_reg;

endmodule

FILE: hw/rtl/alu_with_condition_flags.sv
// flag-producing alu of an 8-bit cpu core as a three-stage pipeline. a word
// enters at every clock edge where start is high; busy is never raised, so a
// new word may follow every cycle. each word's response shows on response for
// exactly one cycle with done high, once it has passed the register of each
// stage (decode, adder, flag merge); the receiver cannot stall
// and must take it in that cycle. words leave in the order they came in.
`include "alu_with_condition_flags_defines.svh"

module alu_with_condition_flags (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  acf_pkg::acf_req_t request,
    output logic              done,
    output acf_pkg::acf_rsp_t response
);

    // handshake
    logic              take;

    // stage 1 -> stage 2
    logic              dec_valid;
    acf_pkg::acf_dec_t dec;

    // stage 2 -> stage 3
    logic              sum_valid;
    acf_pkg::acf_sum_t sum;

    // no stage ever holds, so the pipe always has room
    assign busy = 1'b0;
    assign take = start && !busy;

    // stage 1: operation decode, operand conditioning, logic and shift results,
    // daa correction and all flag values that do not wait on the adder
    acf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (take),
        .request   (request),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    // stage 2: one shared 16-bit adder serves add, sub, inc, dec, daa, add16
    // and add sp,e; nibble and byte (add16: bit 11, 15) carries go with the sum
    acf_adder u_adder (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // stage 3: zero detect, borrow polarity and final flag selection
    acf_flags u_flags (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum       (sum),
        .done      (done),
        .response  (response)
    );

    // every accepted word comes out with done high, and every done comes from an accepted word
    `ACF_ASSERT(a_latency_fwd, take |-> ##3 done)
    `ACF_ASSERT(a_latency_back, done |-> $past(take, 3))
    // words that are not written back carry a zero result
    `ACF_ASSERT(a_no_wb_zero, done && !response.write_back |-> response.result == 16'h0000)
    // only the 16-bit operations may fill the upper byte
    `ACF_ASSERT(a_upper_byte,
        take && (request.operation != acf_pkg::OP_ADD16) &&
        (request.operation != acf_pkg::OP_ADDSP) |-> ##3 (response.result[15:8] == 8'h00))
    `ACF_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
